// ===== hdl/emj_pkg.sv =====
// Shared types and constants for the edge merge join block.
package emj_pkg;

    // Width of every node id field on the ports
    localparam int FIELD_W = 32;

    // Default sizing handed to the top level
    localparam int GROUP_DEPTH_DEF = 32;
    localparam int NODE_BITS_DEF   = 32;

    // Edge kinds on the action field
    localparam logic ACT_LEFT  = 1'b0;
    localparam logic ACT_RIGHT = 1'b1;

    // Controller states
    typedef enum logic {
        ST_IDLE,
        ST_EMIT
    } t_state;

    // Commands from controller to datapath
    typedef struct packed {
        logic grp_upd;   // apply an accepted left edge to the group
        logic start;     // accepted right edge matched: latch target, read first entry
        logic emit;      // load the next pair into the output register
    } t_dp_cmd;

    // Status from datapath to controller
    typedef struct packed {
        logic is_left;   // word at the input is a left edge
        logic right_hit; // word at the input is a right edge of the held key
        logic last_pair; // the entry now read is the last of the group
        logic out_free;  // output register can take a word this cycle
    } t_dp_sts;

endpackage

// ===== hdl/edge_merge_join_core.sv =====
// Top level of the edge merge join: controller plus datapath.
//
// Usage:
//   Input channel (i_in_valid / o_in_stall) takes one edge word: i_action
//   selects a left edge (keyed by target) or a right edge (keyed by source).
//   Output channel (o_out_valid / i_out_stall) gives one joined path word
//   per buffered left source when a right edge matches the held group key;
//   o_last marks the final word of that right edge, o_group_overflow is the
//   sticky flag for left edges dropped on a full group buffer.
// Timing:
//   A left edge is applied to the group on acceptance, with no stall. A
//   matched right edge reads the first buffer entry on acceptance, then
//   gives one pair per cycle while the output register is free, set by
//   the single read port of the buffer memory. Pairs go through the read
//   register into the output register. Unmatched right edges give nothing.
// Reset:
//   Synchronous, active low; clears the group, the overflow flag and the
//   output valid flag. The buffer itself holds no reset state.
// Stall:
//   While i_out_stall is high a held output word stays and emission pauses;
//   the input stays stalled until the last pair is in the output register.
module edge_merge_join_core #(
    parameter int GROUP_DEPTH = emj_pkg::GROUP_DEPTH_DEF,
    parameter int NODE_BITS   = emj_pkg::NODE_BITS_DEF
) (
    input  logic                        i_clk,
    input  logic                        i_rst_n,
    input  logic                        i_in_valid,
    output logic                        o_in_stall,
    input  logic                        i_action,
    input  logic [emj_pkg::FIELD_W-1:0] i_edge_source,
    input  logic [emj_pkg::FIELD_W-1:0] i_edge_target,
    output logic                        o_out_valid,
    input  logic                        i_out_stall,
    output logic [emj_pkg::FIELD_W-1:0] o_out_source,
    output logic [emj_pkg::FIELD_W-1:0] o_out_target,
    output logic                        o_last,
    output logic                        o_group_overflow
);
    import emj_pkg::*;

    // Node ids wider than the port field are limited by the field
    localparam int KEY_W = (NODE_BITS < FIELD_W) ? NODE_BITS : FIELD_W;

    t_dp_cmd cmd;
    t_dp_sts sts;

    emj_ctrl u_ctrl (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_in_valid (i_in_valid),
        .o_in_stall (o_in_stall),
        .i_sts      (sts),
        .o_cmd      (cmd)
    );

    emj_dp #(
        .GROUP_DEPTH (GROUP_DEPTH),
        .KEY_W       (KEY_W)
    ) u_dp (
        .i_clk            (i_clk),
        .i_rst_n          (i_rst_n),
        .i_action         (i_action),
        .i_edge_source    (i_edge_source),
        .i_edge_target    (i_edge_target),
        .i_out_stall      (i_out_stall),
        .o_out_valid      (o_out_valid),
        .o_out_source     (o_out_source),
        .o_out_target     (o_out_target),
        .o_last           (o_last),
        .o_group_overflow (o_group_overflow),
        .i_cmd            (cmd),
        .o_sts            (sts)
    );

endmodule

// ===== hdl/emj_ctrl.sv =====
// Controller state machine: input acceptance and pair emission sequencing.
module emj_ctrl (
    input  logic             i_clk,
    input  logic             i_rst_n,
    input  logic             i_in_valid,
    output logic             o_in_stall,
    input  emj_pkg::t_dp_sts i_sts,
    output emj_pkg::t_dp_cmd o_cmd
);
    import emj_pkg::*;

    t_state r_state;
    t_state n_state;

    // State register
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= ST_IDLE;
        end else begin
            r_state <= n_state;
        end
    end

    // Next state and commands
    always_comb begin
        n_state       = r_state;
        o_in_stall    = 1'b1;
        o_cmd.grp_upd = 1'b0;
        o_cmd.start   = 1'b0;
        o_cmd.emit    = 1'b0;
        unique case (r_state)
            ST_IDLE: begin
                o_in_stall = 1'b0;
                if (i_in_valid) begin
                    if (i_sts.is_left) begin
                        o_cmd.grp_upd = 1'b1;
                    end else if (i_sts.right_hit) begin
                        o_cmd.start = 1'b1;
                        n_state     = ST_EMIT;
                    end
                end
            end
            ST_EMIT: begin
                // advance one pair per free output slot
                if (i_sts.out_free) begin
                    o_cmd.emit = 1'b1;
                    if (i_sts.last_pair) begin
                        n_state = ST_IDLE;
                    end
                end
            end
            default: begin
                n_state = ST_IDLE;
            end
        endcase
    end

endmodule

// ===== hdl/emj_dp.sv =====
// Datapath: group key, source buffer memory, read index and output register.
module emj_dp #(
    parameter int GROUP_DEPTH = emj_pkg::GROUP_DEPTH_DEF,
    parameter int KEY_W       = emj_pkg::NODE_BITS_DEF
) (
    input  logic                           i_clk,
    input  logic                           i_rst_n,
    input  logic                           i_action,
    input  logic [emj_pkg::FIELD_W-1:0]    i_edge_source,
    input  logic [emj_pkg::FIELD_W-1:0]    i_edge_target,
    input  logic                           i_out_stall,
    output logic                           o_out_valid,
    output logic [emj_pkg::FIELD_W-1:0]    o_out_source,
    output logic [emj_pkg::FIELD_W-1:0]    o_out_target,
    output logic                           o_last,
    output logic                           o_group_overflow,
    input  emj_pkg::t_dp_cmd               i_cmd,
    output emj_pkg::t_dp_sts               o_sts
);
    import emj_pkg::*;

    localparam int IDX_W = (GROUP_DEPTH > 1) ? $clog2(GROUP_DEPTH) : 1;
    localparam int CNT_W = $clog2(GROUP_DEPTH + 1);

    // Group state
    logic [KEY_W-1:0] r_key;
    logic             r_grp_valid;
    logic [CNT_W-1:0] r_count;
    logic             r_overflow;

    // Source buffer
    logic [KEY_W-1:0] mem [GROUP_DEPTH];
    logic [KEY_W-1:0] r_rd_data;

    // Emission state
    logic [IDX_W-1:0] r_idx;
    logic [KEY_W-1:0] r_tgt;

    // Output register
    logic                r_out_valid;
    logic [FIELD_W-1:0]  r_out_source;
    logic [FIELD_W-1:0]  r_out_target;
    logic                r_out_last;
    logic                r_out_ovf;

    logic [KEY_W-1:0] key_tgt;
    logic [KEY_W-1:0] key_src;
    logic             new_group;
    logic             grp_full;
    logic             last_pair;
    logic             out_free;
    logic             wr_en;
    logic [IDX_W-1:0] wr_addr;
    logic             rd_en;
    logic [IDX_W-1:0] rd_addr;

    // Reduce node ids to the node width
    assign key_tgt = i_edge_target[KEY_W-1:0];
    assign key_src = i_edge_source[KEY_W-1:0];

    assign new_group = !r_grp_valid || (key_tgt != r_key);
    assign grp_full  = (r_count == CNT_W'(GROUP_DEPTH));
    assign last_pair = ((CNT_W'(r_idx) + CNT_W'(1)) == r_count);
    assign out_free  = !r_out_valid || !i_out_stall;

    // Status to controller
    assign o_sts.is_left   = (i_action == ACT_LEFT);
    assign o_sts.right_hit = (i_action == ACT_RIGHT) && r_grp_valid && (key_src == r_key);
    assign o_sts.last_pair = last_pair;
    assign o_sts.out_free  = out_free;

    // Buffer write and read ports
    assign wr_en   = i_cmd.grp_upd && (new_group || !grp_full);
    assign wr_addr = new_group ? '0 : r_count[IDX_W-1:0];
    assign rd_en   = i_cmd.start || (i_cmd.emit && !last_pair);
    assign rd_addr = i_cmd.start ? '0 : r_idx + IDX_W'(1);

    always_ff @(posedge i_clk) begin
        if (wr_en) begin
            mem[wr_addr] <= key_src;
        end
        if (rd_en) begin
            r_rd_data <= mem[rd_addr];
        end
    end

    // Group bookkeeping
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_key       <= '0;
            r_grp_valid <= 1'b0;
            r_count     <= '0;
            r_overflow  <= 1'b0;
        end else if (i_cmd.grp_upd) begin
            if (new_group) begin
                r_key       <= key_tgt;
                r_grp_valid <= 1'b1;
                r_count     <= CNT_W'(1);
            end else if (!grp_full) begin
                r_count <= r_count + CNT_W'(1);
            end else begin
                // drop the edge and remember it
                r_overflow <= 1'b1;
            end
        end
    end

    // Read index and right-edge target
    always_ff @(posedge i_clk) begin
        if (i_cmd.start) begin
            r_idx <= '0;
            r_tgt <= i_edge_target[KEY_W-1:0];
        end else if (i_cmd.emit) begin
            r_idx <= r_idx + IDX_W'(1);
        end
    end

    // Output register: load on emit, drop once taken
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (i_cmd.emit) begin
            r_out_valid <= 1'b1;
        end else if (!i_out_stall) begin
            r_out_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_cmd.emit) begin
            r_out_source <= FIELD_W'(r_rd_data);
            r_out_target <= FIELD_W'(r_tgt);
            r_out_last   <= last_pair;
            r_out_ovf    <= r_overflow;
        end
    end

    assign o_out_valid      = r_out_valid;
    assign o_out_source     = r_out_source;
    assign o_out_target     = r_out_target;
    assign o_last           = r_out_last;
    assign o_group_overflow = r_out_ovf;

endmodule

// ===== sim/edge_merge_join_checker.sv =====
// Checker for the edge merge join: watches both channels, predicts joined paths, compares them.
`timescale 1ns / 1ps

module edge_merge_join_checker (
    input  logic                        i_clk,
    input  logic                        i_rst_n,
    input  logic                        i_in_valid,
    input  logic                        i_in_stall,
    input  logic                        i_action,
    input  logic [emj_pkg::FIELD_W-1:0] i_edge_source,
    input  logic [emj_pkg::FIELD_W-1:0] i_edge_target,
    input  logic                        i_out_valid,
    input  logic                        i_out_stall,
    input  logic [emj_pkg::FIELD_W-1:0] i_out_source,
    input  logic [emj_pkg::FIELD_W-1:0] i_out_target,
    input  logic                        i_last,
    input  logic                        i_group_overflow,
    output int                          o_fail_count,
    output int                          o_pending
);
    import emj_pkg::*;

    localparam int GROUP_DEPTH = GROUP_DEPTH_DEF;
    localparam int NODE_BITS   = NODE_BITS_DEF;
    localparam logic [FIELD_W-1:0] NODE_MASK =
        (NODE_BITS >= FIELD_W) ? {FIELD_W{1'b1}} : FIELD_W'((64'd1 << NODE_BITS) - 64'd1);
    localparam int PRINT_CAP = 200;

    // One joined path word as it should leave the block
    typedef struct packed {
        logic [FIELD_W-1:0] src;
        logic [FIELD_W-1:0] dst;
        logic               last;
        logic               ovf;
    } t_path;

    // Predicted group state
    logic [FIELD_W-1:0] grp_key;
    logic               grp_held;
    int                 grp_cnt;
    logic [FIELD_W-1:0] grp_src [GROUP_DEPTH];
    logic               ovf_sticky;

    t_path path_q[$];
    int    fail_total = 0;

    assign o_fail_count = fail_total;

    task automatic report_mismatch(input string what);
        if (fail_total < PRINT_CAP) begin
            $display("%0t ns checker: %s", $time, what);
        end
        fail_total++;
    endtask

    // Apply one accepted edge word to the group and queue the paths it joins
    task automatic apply_edge(input logic act, input logic [FIELD_W-1:0] src,
                              input logic [FIELD_W-1:0] dst);
        logic [FIELD_W-1:0] s_id;
        logic [FIELD_W-1:0] d_id;
        t_path              p;
        s_id = src & NODE_MASK;
        d_id = dst & NODE_MASK;
        if (act == ACT_LEFT) begin
            if (!grp_held || d_id != grp_key) begin
                // new key: drop the old group, start over with this source
                grp_key    = d_id;
                grp_held   = 1'b1;
                grp_src[0] = s_id;
                grp_cnt    = 1;
            end else if (grp_cnt < GROUP_DEPTH) begin
                grp_src[grp_cnt] = s_id;
                grp_cnt++;
            end else begin
                // buffer full: drop the entry, flag it for good
                ovf_sticky = 1'b1;
            end
        end else if (grp_held && s_id == grp_key) begin
            // matched right edge: replay the whole group in buffer order
            for (int k = 0; k < grp_cnt; k++) begin
                p.src  = grp_src[k];
                p.dst  = d_id;
                p.last = (k == grp_cnt - 1);
                p.ovf  = ovf_sticky;
                path_q = {path_q, p};
            end
        end
    endtask

    // Compare one accepted output word with the oldest expected path
    task automatic check_path();
        t_path want;
        if (path_q.size() == 0) begin
            report_mismatch($sformatf("unexpected word src=%h tgt=%h last=%b ovf=%b",
                i_out_source, i_out_target, i_last, i_group_overflow));
        end else begin
            want = path_q.pop_front();
            if (i_out_source !== want.src || i_out_target !== want.dst ||
                i_last !== want.last || i_group_overflow !== want.ovf) begin
                report_mismatch($sformatf(
                    "got src=%h tgt=%h last=%b ovf=%b, want src=%h tgt=%h last=%b ovf=%b",
                    i_out_source, i_out_target, i_last, i_group_overflow,
                    want.src, want.dst, want.last, want.ovf));
            end
        end
    endtask

    // Track both channels on every rising edge
    always @(posedge i_clk) begin
        if (!i_rst_n) begin
            grp_key    = '0;
            grp_held   = 1'b0;
            grp_cnt    = 0;
            ovf_sticky = 1'b0;
            path_q.delete();
            o_pending <= 0;
        end else begin
            if (i_out_valid && !i_out_stall) begin
                check_path();
            end
            if (i_in_valid && !i_in_stall) begin
                apply_edge(i_action, i_edge_source, i_edge_target);
            end
            o_pending <= path_q.size();
        end
    end

endmodule

// ===== sim/tb_top.sv =====
// Top of the edge merge join testbench: clock, reset, edge stimulus, output stall and verdict.
`timescale 1ns / 1ps

module tb_top;
    import emj_pkg::*;

    localparam int GROUP_DEPTH    = GROUP_DEPTH_DEF;
    localparam int ITEM_TARGET    = 460;
    localparam int WATCHDOG_LIMIT = 1000;
    localparam int DRAIN_CYCLES   = 40;

    logic               i_clk;
    logic               i_rst_n;
    logic               i_in_valid;
    logic               o_in_stall;
    logic               i_action;
    logic [FIELD_W-1:0] i_edge_source;
    logic [FIELD_W-1:0] i_edge_target;
    logic               o_out_valid;
    logic               i_out_stall;
    logic [FIELD_W-1:0] o_out_source;
    logic [FIELD_W-1:0] o_out_target;
    logic               o_last;
    logic               o_group_overflow;

    int fail_count;
    int pending;
    int items_done = 0;
    int idle_cycles = 0;
    int gap_pct = 15;
    int stall_pct = 15;
    logic idle_on = 1'b1;

    edge_merge_join_core uut (
        .i_clk           (i_clk),
        .i_rst_n         (i_rst_n),
        .i_in_valid      (i_in_valid),
        .o_in_stall      (o_in_stall),
        .i_action        (i_action),
        .i_edge_source   (i_edge_source),
        .i_edge_target   (i_edge_target),
        .o_out_valid     (o_out_valid),
        .i_out_stall     (i_out_stall),
        .o_out_source    (o_out_source),
        .o_out_target    (o_out_target),
        .o_last          (o_last),
        .o_group_overflow(o_group_overflow)
    );

    edge_merge_join_checker join_chk (
        .i_clk           (i_clk),
        .i_rst_n         (i_rst_n),
        .i_in_valid      (i_in_valid),
        .i_in_stall      (o_in_stall),
        .i_action        (i_action),
        .i_edge_source   (i_edge_source),
        .i_edge_target   (i_edge_target),
        .i_out_valid     (o_out_valid),
        .i_out_stall     (i_out_stall),
        .i_out_source    (o_out_source),
        .i_out_target    (o_out_target),
        .i_last          (o_last),
        .i_group_overflow(o_group_overflow),
        .o_fail_count    (fail_count),
        .o_pending       (pending)
    );

    // 10 ns clock
    always begin
        i_clk = 1'b0;
        #5;
        i_clk = 1'b1;
        #5;
    end

    // Watchdog: end the run after too long without any word moving
    always @(posedge i_clk) begin
        if ((i_in_valid && !o_in_stall) || (o_out_valid && !i_out_stall)) begin
            idle_cycles <= 0;
        end else begin
            idle_cycles <= idle_cycles + 1;
            if (idle_cycles >= WATCHDOG_LIMIT) begin
                $display("tb_top: done, errors");
                $finish;
            end
        end
    end

    // Output stall in random bursts
    initial begin
        i_out_stall = 1'b0;
        forever begin
            @(negedge i_clk);
            if (idle_on && $urandom_range(0, 99) < stall_pct) begin
                i_out_stall <= 1'b1;
                repeat ($urandom_range(1, 18)) @(negedge i_clk);
                i_out_stall <= 1'b0;
            end
        end
    end

    // Offer one edge word, hold it until accepted; starts and ends at a falling edge
    task automatic send_edge(input logic act, input logic [FIELD_W-1:0] src,
                             input logic [FIELD_W-1:0] dst);
        if (idle_on && $urandom_range(0, 99) < gap_pct) begin
            i_in_valid <= 1'b0;
            repeat ($urandom_range(1, 18)) @(negedge i_clk);
        end
        i_in_valid    <= 1'b1;
        i_action      <= act;
        i_edge_source <= src;
        i_edge_target <= dst;
        @(posedge i_clk);
        while (o_in_stall) @(posedge i_clk);
        @(negedge i_clk);
        if (act == ACT_LEFT) begin
            items_done++;
        end
    endtask

    // Hold the input until every expected path has come out
    task automatic drain_pause();
        i_in_valid <= 1'b0;
        @(negedge i_clk);
        while (pending != 0) @(negedge i_clk);
    endtask

    // One group of left edges with random content, then right edges that replay it
    task automatic group_run(input bit force_overflow);
        logic [FIELD_W-1:0] key;
        int                 n_left;
        int                 n_hit;
        int                 pick;
        key  = $urandom;
        pick = $urandom_range(0, 99);
        if (force_overflow) begin
            n_left = GROUP_DEPTH + 2;
        end else if (pick < 60) begin
            n_left = $urandom_range(1, 4);
        end else if (pick < 85) begin
            n_left = $urandom_range(5, GROUP_DEPTH - 1);
        end else if (pick < 93) begin
            n_left = GROUP_DEPTH;
        end else begin
            n_left = $urandom_range(GROUP_DEPTH + 1, GROUP_DEPTH + 4);
        end

        for (int k = 0; k < n_left; k++) begin
            pick = $urandom_range(0, 99);
            if (pick < 4) begin
                // stray right edge inside the group: ignored
                send_edge(ACT_RIGHT, key + 32'd1, $urandom);
            end else if (pick < 7) begin
                // break the group with a foreign key; the rest starts afresh
                send_edge(ACT_LEFT, $urandom, key ^ 32'h1);
            end
            send_edge(ACT_LEFT, $urandom, key);
        end

        n_hit = $urandom_range(0, 3);
        for (int k = 0; k < n_hit; k++) begin
            if ($urandom_range(0, 99) < 20) begin
                send_edge(ACT_RIGHT, key ^ (32'd1 << $urandom_range(0, 31)), $urandom);
            end
            send_edge(ACT_RIGHT, key, $urandom);
            items_done++;
        end

        // noise word with any content
        if ($urandom_range(0, 99) < 15) begin
            send_edge(1'($urandom_range(0, 1)), $urandom, $urandom);
        end
    endtask

    initial begin
        int seq_no;
        i_rst_n       = 1'b0;
        i_in_valid    = 1'b0;
        i_action      = ACT_LEFT;
        i_edge_source = '0;
        i_edge_target = '0;
        repeat (12) @(posedge i_clk);
        @(negedge i_clk);
        i_rst_n <= 1'b1;

        // right edge of the reset key with no group held
        send_edge(ACT_RIGHT, 32'h0000_0000, 32'h0000_0000);
        // group at key zero, then a matched right edge replays all three
        send_edge(ACT_LEFT, 32'hFFFF_FFFF, 32'h0000_0000);
        send_edge(ACT_LEFT, 32'h0000_0000, 32'h0000_0000);
        send_edge(ACT_LEFT, 32'hA5A5_A5A5, 32'h0000_0000);
        send_edge(ACT_RIGHT, 32'h0000_0000, 32'hFFFF_FFFF);
        items_done++;
        // unmatched right edge leaves the group alone
        send_edge(ACT_RIGHT, 32'hFFFF_FFFF, 32'h0000_0000);
        // repeated right edge replays the same group
        send_edge(ACT_RIGHT, 32'h0000_0000, 32'h5A5A_5A5A);
        items_done++;
        // new key at the top of the range
        send_edge(ACT_LEFT, 32'h0000_0001, 32'hFFFF_FFFF);
        send_edge(ACT_RIGHT, 32'hFFFF_FFFE, 32'h0000_0001);
        send_edge(ACT_RIGHT, 32'hFFFF_FFFF, 32'h0000_0000);
        items_done++;
        send_edge(ACT_LEFT, 32'h0000_0007, 32'h0000_0010);
        send_edge(ACT_LEFT, 32'h0000_0008, 32'h0000_0010);
        send_edge(ACT_RIGHT, 32'h0000_0010, 32'h0000_0020);
        items_done++;
        // lower key out of order discards the group
        send_edge(ACT_LEFT, 32'h0000_0009, 32'h0000_0005);
        send_edge(ACT_RIGHT, 32'h0000_0010, 32'h0000_0000);
        send_edge(ACT_RIGHT, 32'h0000_0005, 32'hFFFF_FFFF);
        items_done++;
        drain_pause();

        // random groups until enough words went in
        seq_no = 0;
        while (items_done < ITEM_TARGET) begin
            idle_on <= !((seq_no >= 10 && seq_no < 14) || items_done >= ITEM_TARGET - 60);
            case ($urandom_range(0, 2))
                0: gap_pct = 0;
                1: gap_pct = 8;
                default: gap_pct = 30;
            endcase
            case ($urandom_range(0, 2))
                0: stall_pct <= 0;
                1: stall_pct <= 10;
                default: stall_pct <= 35;
            endcase
            group_run(seq_no == 20);
            if (seq_no % 12 == 11) begin
                drain_pause();
            end
            seq_no++;
        end
        i_in_valid <= 1'b0;

        // let the last paths come out
        while (pending != 0) @(posedge i_clk);
        repeat (DRAIN_CYCLES) @(posedge i_clk);

        if (fail_count == 0 && pending == 0) begin
            $display("tb_top: done, clean");
        end else begin
            $display("tb_top: done, errors");
        end
        $finish;
    end

endmodule

// ===== filelist.f =====
hdl/emj_pkg.sv
hdl/emj_ctrl.sv
hdl/emj_dp.sv
hdl/edge_merge_join_core.sv
sim/edge_merge_join_checker.sv
sim/tb_top.sv
